FILE: hw/rtl/asfr_pkg.sv
// asfr_pkg: types and constants for the addressed serial frame receiver
// no dependencies; imported by addressed_serial_frame_receiver
`timescale 1ns / 1ps
`default_nettype none

package asfr_pkg;

	localparam logic [7:0] MIN_FRAME_LEN = 8'd2;
	localparam logic [7:0] MAX_FRAME_LEN = 8'd128;

	localparam logic [7:0] CH_COLON = 8'd58;
	localparam logic [7:0] CH_QUERY = 8'd63;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_LF    = 8'd10;

	localparam logic [7:0] DEVICE_ID_RESET = 8'd1;
	localparam logic [7:0] BROADCAST_ID    = 8'd0;

	typedef enum logic [1:0] {
		EV_PAYLOAD = 2'd0,
		EV_INFO    = 2'd1,
		EV_FOREIGN = 2'd2
	} event_kind_t;

	typedef enum logic [4:0] {
		PH_HUNT   = 5'b00001,
		PH_ID     = 5'b00010,
		PH_LEN    = 5'b00100,
		PH_RECV   = 5'b01000,
		PH_UNLOAD = 5'b10000
	} phase_t;

	typedef struct packed {
		event_kind_t kind;
		logic [7:0]  data;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/addressed_serial_frame_receiver.sv
// addressed_serial_frame_receiver: parses addressed frames from a received byte stream
// depends on asfr_pkg (phase codes, event codes, character constants)
// each result beat is registered in the output register, or in the skid register while the output register is held
// throughput: one input beat per cycle while in_stall is low; the parser state updates on each accepted beat
// an output register plus one skid register decouple out_stall from in_stall
// in_stall rises only while the skid register holds a beat
// reset (arst_n low, asynchronous): hunting, history and counters cleared, device_id = 1
`timescale 1ns / 1ps
`default_nettype none

module addressed_serial_frame_receiver
	import asfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,

	// configuration: own node address
	input  wire logic       device_id_we,
	input  wire logic [7:0] device_id_wdata,

	// received bytes
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,

	// events
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      event_kind,
	output logic [7:0]      payload_byte,
	output logic            frame_last
);

	// parser state
	logic [7:0] device_id_q;
	phase_t     phase_q;
	logic [7:0] recent0_q, recent1_q, recent2_q;   // oldest .. newest hunting byte
	logic       frame_for_me_q;
	logic [7:0] frame_length_q;
	logic [7:0] byte_position_q;

	// next-state values
	phase_t     phase_d;
	logic [7:0] recent0_d, recent1_d, recent2_d;
	logic       frame_for_me_d;
	logic [7:0] frame_length_d;
	logic [7:0] byte_position_d;
	logic [7:0] pos_inc;
	logic [7:0] len_dec;

	// result of the current beat
	logic       res_valid;
	result_t    res;

	// output register and skid register
	logic       out_valid_q;
	result_t    out_q;
	logic       skid_valid_q;
	result_t    skid_q;

	logic       in_accept;
	logic       out_take;

	assign in_stall  = skid_valid_q;
	assign in_accept = in_valid && !skid_valid_q;
	assign out_take  = out_valid_q && !out_stall;

	assign pos_inc = byte_position_q + 8'd1;
	assign len_dec = frame_length_q - 8'd1;

	// parser next state and result
	always_comb begin
		phase_d         = phase_q;
		recent0_d       = recent0_q;
		recent1_d       = recent1_q;
		recent2_d       = recent2_q;
		frame_for_me_d  = frame_for_me_q;
		frame_length_d  = frame_length_q;
		byte_position_d = byte_position_q;
		res_valid       = 1'b0;
		res.kind        = EV_PAYLOAD;
		res.data        = 8'd0;
		res.last        = 1'b0;

		case (phase_q)
			PH_ID: begin
				// address compared with device_id and the broadcast id as the byte arrives
				frame_for_me_d = (rx_byte == device_id_q) || (rx_byte == BROADCAST_ID);
				frame_length_d = 8'd0;
				phase_d        = PH_LEN;
			end
			PH_LEN: begin
				if (!(rx_byte inside {[MIN_FRAME_LEN:MAX_FRAME_LEN]})) begin
					// bad length, back to hunting
					frame_length_d = 8'd0;
					phase_d        = PH_HUNT;
				end else begin
					frame_length_d  = rx_byte;
					byte_position_d = 8'd0;
					phase_d         = frame_for_me_q ? PH_RECV : PH_UNLOAD;
				end
			end
			PH_RECV: begin
				res_valid = 1'b1;
				res.kind  = EV_PAYLOAD;
				res.data  = rx_byte;
				if (pos_inc >= frame_length_q) begin
					// final payload byte
					byte_position_d = 8'd0;
					frame_length_d  = 8'd0;
					phase_d         = PH_HUNT;
					res.last        = 1'b1;
				end else begin
					byte_position_d = pos_inc;
				end
			end
			PH_UNLOAD: begin
				// foreign frame is drained silently, completion on its last byte
				frame_length_d = len_dec;
				if (len_dec == 8'd0) begin
					byte_position_d = 8'd0;
					phase_d         = PH_HUNT;
					res_valid       = 1'b1;
					res.kind        = EV_FOREIGN;
				end
			end
			default: begin
				// hunting: shift history, look for start pair then info request
				phase_d   = PH_HUNT;
				recent0_d = recent1_q;
				recent1_d = recent2_q;
				recent2_d = rx_byte;
				if (recent2_q == CH_COLON && rx_byte == CH_COLON) begin
					recent0_d = 8'd0;
					recent1_d = 8'd0;
					recent2_d = 8'd0;
					phase_d   = PH_ID;
				end else if (recent1_q == CH_QUERY && recent2_q == CH_CR
						&& rx_byte == CH_LF) begin
					res_valid = 1'b1;
					res.kind  = EV_INFO;
				end
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q <= DEVICE_ID_RESET;
		end else if (device_id_we) begin
			device_id_q <= device_id_wdata;
		end
	end

	// parser state update on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HUNT;
			recent0_q       <= 8'd0;
			recent1_q       <= 8'd0;
			recent2_q       <= 8'd0;
			frame_for_me_q  <= 1'b0;
			frame_length_q  <= 8'd0;
			byte_position_q <= 8'd0;
		end else if (in_accept) begin
			phase_q         <= phase_d;
			recent0_q       <= recent0_d;
			recent1_q       <= recent1_d;
			recent2_q       <= recent2_d;
			frame_for_me_q  <= frame_for_me_d;
			frame_length_q  <= frame_length_d;
			byte_position_q <= byte_position_d;
		end
	end

	// output register with skid: a new result lands in the skid register
	// when the output register is full and held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || out_take) begin
			out_valid_q <= in_accept && res_valid;
		end else if (in_accept && res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload of the output and skid registers
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || out_take) begin
			out_q <= res;
		end else begin
			skid_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = out_q.kind;
	assign payload_byte = out_q.data;
	assign frame_last   = out_q.last;

endmodule

`default_nettype wire
